/* hw/rtl/lattice_random_walk_3d_defines.svh */
// Assertion macros for the lattice random walk block.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef LATTICE_RANDOM_WALK_3D_DEFINES_SVH
`define LATTICE_RANDOM_WALK_3D_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define LRW3D_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Implication checked in the same cycle.
`define LRW3D_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/lrw3d_pkg.sv */
// Shared types and constants for the lattice random walk block.
// No dependencies; imported by every other file of the block but the defines header.
package lrw3d_pkg;

	// Coordinate and distance geometry.
	localparam int COORD_BITS     = 16;
	localparam int DIST_FRAC_BITS = 8;
	localparam int NUM_AXES       = 3;
	localparam int UNIFORM_W      = 32;
	localparam int BUCKET_W       = UNIFORM_W + 3;
	localparam int SQ_W           = 2 * COORD_BITS;
	localparam int ROOT_BITS      = COORD_BITS + DIST_FRAC_BITS;
	localparam int REM_W          = ROOT_BITS + 2;
	localparam int RAD_W          = 2 * ROOT_BITS;
	localparam int IT_W           = $clog2(ROOT_BITS);
	localparam int SQ_CNT_W       = $clog2(NUM_AXES + 1);

	// Command queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [SQ_W-1:0]              sq_t;
	typedef logic [ROOT_BITS-1:0]         root_t;

	// Saturation limits; the most negative code is never produced.
	localparam coord_t COORD_MAX   = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_LOW   = -COORD_MAX;
	localparam coord_t COORD_NEVER = {1'b1, {(COORD_BITS-1){1'b0}}};

	typedef enum logic {
		OP_STEP  = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	// One classified item as it travels through the queue.
	typedef struct packed {
		logic  clear;
		axis_t axis;
		logic  fwd;
	} cmd_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT,
		ST_DONE
	} back_state_t;

endpackage

/* hw/rtl/lrw3d_in_if.sv */
// Input channel of the lattice random walk block: valid/ready plus item fields.
// Depends on lrw3d_pkg.
interface lrw3d_in_if import lrw3d_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 op;
	logic [UNIFORM_W-1:0] uniform;

	modport source (output valid, output op, output uniform, input ready);
	modport sink (input valid, input op, input uniform, output ready);
endinterface

/* hw/rtl/lrw3d_out_if.sv */
// Result channel of the lattice random walk block: valid/ready plus result fields.
// Depends on lrw3d_pkg.
interface lrw3d_out_if import lrw3d_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t pos_x;
	coord_t pos_y;
	coord_t pos_z;
	sq_t    dist_squared;
	root_t  dist_fixed;

	modport source (output valid, output pos_x, output pos_y, output pos_z,
		output dist_squared, output dist_fixed, input ready);
	modport sink (input valid, input pos_x, input pos_y, input pos_z,
		input dist_squared, input dist_fixed, output ready);
endinterface

/* hw/rtl/lattice_random_walk_3d.sv */
// Lattice random walk, 3D: top level joining front, command queue and back.
// Depends on lrw3d_pkg, the channel interfaces, lrw3d_front, lrw3d_queue,
// lrw3d_back and lattice_random_walk_3d_defines.svh.
//
// Usage: each item on req carries op (step or clear) and a 32-bit uniform
// fraction. A step moves one coordinate by one lattice unit, chosen by the
// bucket floor(6u); a clear returns the walker to the origin. Every item gives
// exactly one result on rsp: the three coordinates, the squared distance and
// the distance with 8 fraction bits, rounded down.
// The back part handles one item at a time: the shared squaring multiplier
// squares the coordinates in turn, then the digit-by-digit square root gives
// one root bit per cycle.
// The front stage and a two-entry queue take up to three further items while
// the back is busy, so req stays ready until they fill.
// Reset clears the position to the origin and empties the queue and the
// result register. When rsp is stalled the result holds in its register, the
// back waits with the next result finished, and req backs up through the queue.
`include "lattice_random_walk_3d_defines.svh"
module lattice_random_walk_3d import lrw3d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	lrw3d_in_if.sink     req,
	lrw3d_out_if.source  rsp
);

	logic    q_push;
	logic    q_pop;
	cmd_t    push_cmd;
	cmd_t    pop_cmd;
	q_stat_t q_stat;
	logic    coord_ok;
	logic    zero_agree;

	// Accepts and classifies items.
	lrw3d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.q_stat   (q_stat),
		.push     (q_push),
		.push_cmd (push_cmd)
	);

	// Decoupling queue.
	lrw3d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.stat     (q_stat)
	);

	// Position update, distance computation and result register.
	lrw3d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (q_stat),
		.pop_cmd (pop_cmd),
		.pop     (q_pop),
		.rsp     (rsp)
	);

	// Terms checked below on every result.
	assign coord_ok   = (rsp.pos_x != COORD_NEVER) && (rsp.pos_y != COORD_NEVER) &&
		(rsp.pos_z != COORD_NEVER);
	assign zero_agree = ((rsp.dist_squared == '0) == (rsp.dist_fixed == '0));

	// Queue is never written while full nor read while empty.
	`LRW3D_ASSERT_IMPLY(a_no_overflow, q_push, !q_stat.full, "push into full queue")
	`LRW3D_ASSERT_IMPLY(a_no_underflow, q_pop, !q_stat.empty, "pop from empty queue")
	// Saturation never produces the most negative coordinate code.
	`LRW3D_ASSERT_ALWAYS(a_sat_limit, !rsp.valid || coord_ok, "coordinate below limit")
	// Distance is zero exactly when the squared distance is zero.
	`LRW3D_ASSERT_IMPLY(a_dist_zero, rsp.valid, zero_agree, "distance zero mismatch")

endmodule

/* hw/rtl/lrw3d_front.sv */
// Front part: accepts input items and classifies them into move commands.
// Depends on lrw3d_pkg and lrw3d_in_if.
module lrw3d_front import lrw3d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	lrw3d_in_if.sink     req,
	input  q_stat_t      q_stat,
	output logic         push,
	output cmd_t         push_cmd
);

	logic                cmd_valid_s1;
	cmd_t                cmd_s1;
	cmd_t                cmd_new;
	logic [BUCKET_W-1:0] bucket;
	logic [2:0]          k;
	logic                accept;

	// The stage is free when empty or when its command moves into the queue.
	assign push     = cmd_valid_s1 && !q_stat.full;
	assign push_cmd = cmd_s1;
	assign req.ready = !cmd_valid_s1 || !q_stat.full;
	assign accept   = req.valid && req.ready;

	// Bucket k = floor(6u): the top three bits of 6 * uniform.
	always_comb begin
		bucket = (BUCKET_W'(req.uniform) << 2) + (BUCKET_W'(req.uniform) << 1);
		k      = bucket[BUCKET_W-1 -: 3];
		cmd_new.clear = (req.op == OP_CLEAR);
		cmd_new.axis  = axis_t'(k[2:1]);
		cmd_new.fwd   = k[0];
	end

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (accept) begin
			cmd_valid_s1 <= 1'b1;
		end else if (push) begin
			cmd_valid_s1 <= 1'b0;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_new;
		end
	end

endmodule

/* hw/rtl/lrw3d_queue.sv */
// Short command queue that decouples the front part from the back part.
// Depends on lrw3d_pkg.
module lrw3d_queue import lrw3d_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    pop_cmd,
	output q_stat_t stat
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_cmd    = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* hw/rtl/lrw3d_back.sv */
// Back part: applies commands to the position, squares and sums the
// coordinates, takes the fixed-point square root and holds the result.
// Depends on lrw3d_pkg and lrw3d_out_if.
module lrw3d_back import lrw3d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_stat_t    q_stat,
	input  cmd_t       pop_cmd,
	output logic       pop,
	lrw3d_out_if.source rsp
);

	localparam logic [SQ_CNT_W-1:0] SQ_LAST = SQ_CNT_W'(NUM_AXES);

	back_state_t          state_q, state_d;
	logic                 load_out;
	coord_t               pos_q  [NUM_AXES];
	coord_t               pos_n  [NUM_AXES];
	coord_t               line_q [NUM_AXES];
	coord_t               cur;
	coord_t               stepped;
	logic signed [SQ_W-1:0] sq_signed;
	sq_t                  prod_q;
	sq_t                  acc_q;
	sq_t                  sq_sum;
	logic [SQ_CNT_W-1:0]  sq_cnt_q;
	logic [RAD_W-1:0]     rad_q;
	logic [REM_W-1:0]     rem_q;
	logic [REM_W-1:0]     rem_sh;
	logic [REM_W-1:0]     trial;
	logic [REM_W-1:0]     rem_nx;
	logic                 root_ge;
	root_t                root_q;
	logic [IT_W-1:0]      it_q;
	logic                 rsp_valid_q;
	coord_t               out_x_q, out_y_q, out_z_q;
	sq_t                  out_sq_q;
	root_t                out_dist_q;

	// Next state and sequencing strobes.
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					state_d = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				if (sq_cnt_q == SQ_LAST) begin
					state_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (it_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Saturating unit move of the selected coordinate, or a clear.
	always_comb begin
		case (pop_cmd.axis)
			AXIS_X:  cur = pos_q[0];
			AXIS_Y:  cur = pos_q[1];
			AXIS_Z:  cur = pos_q[2];
			default: cur = pos_q[0];
		endcase
		if (pop_cmd.fwd) begin
			stepped = (cur == COORD_MAX) ? cur : cur + coord_t'(1);
		end else begin
			stepped = (cur == COORD_LOW) ? cur : cur - coord_t'(1);
		end
		for (int a = 0; a < NUM_AXES; a++) begin
			pos_n[a] = pos_q[a];
		end
		case (pop_cmd.axis)
			AXIS_X:  pos_n[0] = stepped;
			AXIS_Y:  pos_n[1] = stepped;
			AXIS_Z:  pos_n[2] = stepped;
			default: pos_n[0] = pos_q[0];
		endcase
		if (pop_cmd.clear) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				pos_n[a] = '0;
			end
		end
	end

	// One square per cycle; the sum adds in the product register in the cycle after it is loaded.
	assign sq_signed = line_q[0] * line_q[0];
	assign sq_sum    = acc_q + prod_q;

	// One root bit per cycle, two radicand bits brought down each time.
	always_comb begin
		rem_sh  = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial   = {root_q, 2'b01};
		root_ge = (rem_sh >= trial);
		rem_nx  = root_ge ? (rem_sh - trial) : rem_sh;
	end

	// Control state, position and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sq_cnt_q    <= '0;
			it_q        <= '0;
			rsp_valid_q <= 1'b0;
			for (int a = 0; a < NUM_AXES; a++) begin
				pos_q[a] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (pop) begin
				sq_cnt_q <= '0;
				for (int a = 0; a < NUM_AXES; a++) begin
					pos_q[a] <= pos_n[a];
				end
			end else if (state_q == ST_SQUARE) begin
				sq_cnt_q <= sq_cnt_q + 1'b1;
			end
			if (state_q == ST_SQUARE) begin
				it_q <= IT_W'(ROOT_BITS - 1);
			end else if (state_q == ST_ROOT) begin
				it_q <= it_q - 1'b1;
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				line_q[a] <= pos_n[a];
			end
			prod_q <= '0;
			acc_q  <= '0;
		end else if (state_q == ST_SQUARE) begin
			for (int a = 0; a < NUM_AXES - 1; a++) begin
				line_q[a] <= line_q[a+1];
			end
			line_q[NUM_AXES-1] <= '0;
			prod_q <= sq_t'(sq_signed);
			acc_q  <= sq_sum;
			rad_q  <= RAD_W'(sq_sum) << (2 * DIST_FRAC_BITS);
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == ST_ROOT) begin
			rad_q  <= rad_q << 2;
			rem_q  <= rem_nx;
			root_q <= {root_q[ROOT_BITS-2:0], root_ge};
		end
		if (load_out) begin
			out_x_q    <= pos_q[0];
			out_y_q    <= pos_q[1];
			out_z_q    <= pos_q[2];
			out_sq_q   <= acc_q;
			out_dist_q <= root_q;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.pos_x        = out_x_q;
	assign rsp.pos_y        = out_y_q;
	assign rsp.pos_z        = out_z_q;
	assign rsp.dist_squared = out_sq_q;
	assign rsp.dist_fixed   = out_dist_q;

endmodule

/* verif/lrw3d_tb_pkg.sv */
// Scoreboard for the lattice random walk testbench: walker prediction and result checks.
// Depends on lrw3d_pkg for the coordinate, distance and operation types.
package lrw3d_tb_pkg;
	import lrw3d_pkg::*;

	// One result transfer as it appears on the rsp channel.
	typedef struct packed {
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
		sq_t    dist_squared;
		root_t  dist_fixed;
	} walk_result_t;

	class walk_scoreboard;
		localparam int MAX_REPORTS = 10;

		coord_t       walker[NUM_AXES];
		walk_result_t predicted_q[$];
		int unsigned  items_noted;
		int unsigned  clears_seen;
		int unsigned  held_at_limit;
		int unsigned  results_checked;
		int unsigned  fault_count;

		function new();
			foreach (walker[a]) walker[a] = '0;
			items_noted     = 0;
			clears_seen     = 0;
			held_at_limit   = 0;
			results_checked = 0;
			fault_count     = 0;
		endfunction

		// Largest root with root*root <= r2 scaled by the fraction bits, found bit by bit.
		function longint unsigned floor_root_fixed(longint unsigned r2);
			longint unsigned scaled;
			longint unsigned root;
			longint unsigned trial;
			scaled = r2 << (2 * DIST_FRAC_BITS);
			root   = 0;
			for (int b = ROOT_BITS - 1; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= scaled) root = trial;
			end
			return root;
		endfunction

		// Advance the predicted walker by one accepted item and queue its result.
		function void note_item(op_t op, logic [UNIFORM_W-1:0] uniform);
			logic [BUCKET_W-1:0] scaled;
			logic [2:0]          bucket;
			axis_t               axis;
			coord_t              c;
			longint unsigned     r2;
			walk_result_t        want;
			items_noted++;
			if (op == OP_CLEAR) begin
				foreach (walker[a]) walker[a] = '0;
				clears_seen++;
			end else begin
				// The top three bits of 6*uniform are floor(6u).
				scaled = BUCKET_W'(uniform) * BUCKET_W'(6);
				bucket = scaled[BUCKET_W-1 -: 3];
				axis   = axis_t'(bucket[2:1]);
				c      = walker[axis];
				if (bucket[0]) begin
					if (c < COORD_MAX) c = c + 16'sd1;
					else held_at_limit++;
				end else begin
					if (c > COORD_LOW) c = c - 16'sd1;
					else held_at_limit++;
				end
				walker[axis] = c;
			end
			r2 = 0;
			foreach (walker[a]) r2 += longint'(walker[a]) * longint'(walker[a]);
			want.pos_x        = walker[AXIS_X];
			want.pos_y        = walker[AXIS_Y];
			want.pos_z        = walker[AXIS_Z];
			want.dist_squared = sq_t'(r2);
			want.dist_fixed   = root_t'(floor_root_fixed(r2));
			predicted_q.push_back(want);
		endfunction

		// Compare one result transfer with the oldest prediction.
		function void check_result(walk_result_t got);
			walk_result_t want;
			if (predicted_q.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS)
					$display("unexpected result with no item pending: x=%0d y=%0d z=%0d",
						got.pos_x, got.pos_y, got.pos_z);
				return;
			end
			want = predicted_q.pop_front();
			results_checked++;
			if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
					got.pos_z !== want.pos_z || got.dist_squared !== want.dist_squared ||
					got.dist_fixed !== want.dist_fixed) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS) begin
					$display("result %0d expected x=%0d y=%0d z=%0d r2=%0d dist=%0d",
						results_checked, want.pos_x, want.pos_y, want.pos_z,
						want.dist_squared, want.dist_fixed);
					$display("result %0d got      x=%0d y=%0d z=%0d r2=%0d dist=%0d",
						results_checked, got.pos_x, got.pos_y, got.pos_z,
						got.dist_squared, got.dist_fixed);
				end
			end
		endfunction

		function int unsigned outstanding();
			return predicted_q.size();
		endfunction
	endclass

endpackage

/* verif/lattice_random_walk_3d_tb.sv */
// Top-level testbench for lattice_random_walk_3d: clock, reset, stimulus and pacing.
// Depends on lrw3d_pkg, the lrw3d_in_if/lrw3d_out_if channels and lrw3d_tb_pkg.
module lattice_random_walk_3d_tb import lrw3d_pkg::*, lrw3d_tb_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          SWEEP_STEPS    = 40;
	localparam int          ITEMS_PER_PACE = 200;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned SETTLE_CYCLES  = ROOT_BITS + 16;

	logic clk;
	logic arst_n;

	lrw3d_in_if  req();
	lrw3d_out_if rsp();

	lattice_random_walk_3d u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	walk_scoreboard walk_sb = new();

	// Pacing: percent of cycles the sender idles and the receiver stalls.
	int unsigned pace_send_idle[4]  = '{0, 76, 0, 38};
	int unsigned pace_recv_stall[4] = '{0, 0, 76, 38};
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned holds_requested;

	logic [UNIFORM_W-1:0] bucket_edge[6];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Offer one item, with random idle cycles ahead of it, and wait for its transfer.
	task automatic send_item(input op_t op, input logic [UNIFORM_W-1:0] uniform);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid   <= 1'b1;
		req.op      <= op;
		req.uniform <= uniform;
		do @(posedge clk); while (!req.ready);
		walk_sb.note_item(op, uniform);
	endtask

	// Stop offering and wait until every predicted result has arrived.
	task automatic wait_drained();
		req.valid <= 1'b0;
		while (walk_sb.outstanding() != 0) @(posedge clk);
	endtask

	// Receiver: check each result transfer, then choose ready for the next cycle.
	initial begin
		int unsigned hold_left;
		int unsigned holds_seen;
		rsp.ready  = 1'b0;
		hold_left  = 0;
		holds_seen = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready)
				walk_sb.check_result('{rsp.pos_x, rsp.pos_y, rsp.pos_z,
					rsp.dist_squared, rsp.dist_fixed});
			if (holds_requested != holds_seen) begin
				holds_seen = holds_requested;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: give up after a long run of cycles with no transfer on either channel.
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		req.valid       = 1'b0;
		req.op          = OP_STEP;
		req.uniform     = '0;
		arst_n          = 1'b0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		holds_requested = 0;
		// First uniform value of each bucket k: ceil(k * 2^32 / 6).
		for (int k = 0; k < 6; k++)
			bucket_edge[k] = UNIFORM_W'(((longint'(k) << UNIFORM_W) + 5) / 6);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: both operations, uniform extremes and both sides of every bucket edge.
		send_item(OP_CLEAR, '1);
		send_item(OP_STEP, '0);
		send_item(OP_STEP, '1);
		for (int k = 1; k < 6; k++) begin
			send_item(OP_STEP, bucket_edge[k] - 1'b1);
			send_item(OP_STEP, bucket_edge[k]);
		end
		send_item(OP_CLEAR, $urandom());
		wait_drained();

		// Drift: march x steadily up, then z steadily down.
		send_item(OP_CLEAR, $urandom());
		repeat (SWEEP_STEPS) send_item(OP_STEP, $urandom_range(bucket_edge[2] - 1, bucket_edge[1]));
		repeat (SWEEP_STEPS) send_item(OP_STEP, $urandom_range(bucket_edge[5] - 1, bucket_edge[4]));
		wait_drained();

		// Random walk under each pacing; a long result stall opens the receiver-stall pace.
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = pace_send_idle[p];
			recv_stall_pct = pace_recv_stall[p];
			if (p == 2) holds_requested++;
			repeat (ITEMS_PER_PACE)
				send_item(($urandom_range(31) == 0) ? OP_CLEAR : OP_STEP, $urandom());
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Walked %0d items (%0d clears) with %0d moves held at a coordinate limit,",
			walk_sb.items_noted, walk_sb.clears_seen, walk_sb.held_at_limit);
		$display("under four pacing mixes and a long result stall; %0d results, %0d faults.",
			walk_sb.results_checked, walk_sb.fault_count);
		if (walk_sb.fault_count == 0 && walk_sb.outstanding() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
